// ----- sv/kdcut_pkg.sv -----
// shared constants and codes for the cut-tree rank lookup unit
package kdcut_pkg;

  localparam int MAX_LEVELS_DEF  = 6;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int SLOT_W     = 6;
  localparam int RANK_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TREE_LEVELS = 1'd1;

  // item kinds carried in tuser
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOCATE = 1'b1;

  localparam logic [1:0] AXIS_COUNT_RST  = 2'd3;
  localparam logic [2:0] TREE_LEVELS_RST = 3'd0;

endpackage

// ----- sv/kd_cut_tree_rank_lookup_unit.sv -----
// cut-tree rank lookup: point location by descent through a table of cuts
//
// s_* takes one word per cycle at most. s_tuser is the kind: a load word
// writes cut_value and rank_value into one table slot and gives no result; a
// locate word walks the cut tree from node 1 and yields one m_* word with
// the owner rank and the leaf index. cfg_* writes axis_count (index 0) and
// tree_levels (index 1); it is always ready, and it is to be used while the
// unit idles, which the unit itself does not enforce. A locate word holds
// the input until it is done: the cut memory is read once per level, the
// read of the next node overlapping the compare of the current one, then
// one read of the rank memory gives the owner rank for m_*.
// The result sits in an output register: loads go on while it waits, and a
// locate waits in its final state only until that register is free.
// Reset (rst, synchronous) clears control state and sets axis_count to 3
// and tree_levels to 0; the tables are left as they are, and an entry
// never loaded reads as anything.
module kd_cut_tree_rank_lookup_unit
  import kdcut_pkg::*;
#(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           s_tvalid,
  output logic                                           s_tready,
  // slot, cut_value, rank_value, coord_x, coord_y, coord_z, zero pad
  input  logic [((SLOT_W+RANK_W+4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // action
  input  logic                                           s_tuser,
  output logic                                           m_tvalid,
  input  logic                                           m_tready,
  // owner_rank, leaf_slot, zero pad
  output logic [((RANK_W+SLOT_W+7)/8)*8-1:0]             m_tdata,
  input  logic                                           cfg_valid,
  output logic                                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]                           cfg_index,
  input  logic [CFG_DATA_W-1:0]                          cfg_data
);

  localparam int OUT_W   = ((RANK_W+SLOT_W+7)/8)*8;
  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int LVL_W   = $clog2(MAX_LEVELS+1);
  localparam int NODE_W  = MAX_LEVELS+1;
  localparam int CUT_LO  = SLOT_W;
  localparam int RANK_LO = CUT_LO+COORD_WIDTH;
  localparam int X_LO    = RANK_LO+RANK_W;
  localparam int Y_LO    = X_LO+COORD_WIDTH;
  localparam int Z_LO    = Y_LO+COORD_WIDTH;
  localparam logic [IDX_W:0] DEPTH_V = (IDX_W+1)'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    IDLE,
    WALK,
    DONE
  } state_t;

  state_t state;

  logic [1:0]                axis_count;
  logic [2:0]                tree_levels;
  logic [COORD_WIDTH-1:0]    coord_x;
  logic [COORD_WIDTH-1:0]    coord_y;
  logic [COORD_WIDTH-1:0]    coord_z;
  logic [LVL_W-1:0]          lvl_total;
  logic [LVL_W-1:0]          lvl_cnt;
  logic [1:0]                axis_idx;
  logic [1:0]                axis_last;
  logic [NODE_W-1:0]         node;
  logic [IDX_W-1:0]          node_mod;
  logic [IDX_W-1:0]          pow_mod;
  logic [SLOT_W-1:0]         leaf_cur;
  logic [IDX_W-1:0]          leaf_addr;
  logic [SLOT_W-1:0]         leaf_slot;
  logic [RANK_W-1:0]         owner_rank;

  logic [COORD_WIDTH-1:0]    cut_mem [TABLE_DEPTH];
  logic [RANK_W-1:0]         rank_mem [TABLE_DEPTH];
  logic [COORD_WIDTH-1:0]    cut_q;
  logic [RANK_W-1:0]         rank_q;

  logic                      in_acc;
  logic                      load_acc;
  logic                      locate_acc;
  logic [LVL_W-1:0]          lvl_eff;
  logic [1:0]                axes_eff;
  logic [COORD_WIDTH-1:0]    coord_sel;
  logic                      go_right;
  logic [NODE_W-1:0]         node_next;
  logic [IDX_W:0]            node_dbl;
  logic [IDX_W-1:0]          node_mod_next;
  logic [IDX_W:0]            pow_dbl;
  logic [IDX_W-1:0]          pow_mod_next;
  logic [IDX_W-1:0]          leaf_idx;
  logic                      last_lvl;
  logic [NODE_W-1:0]         leaf_full;
  logic [NODE_W+SLOT_W-1:0]  leaf_ext;
  logic [IDX_W-1:0]          rd_addr;
  logic [IDX_W-1:0]          wr_addr;

  assign s_tready   = (state == IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = s_tvalid && s_tready;
  assign load_acc   = in_acc && (s_tuser == ACT_LOAD);
  assign locate_acc = in_acc && (s_tuser == ACT_LOCATE);

  assign m_tdata = OUT_W'({leaf_slot, owner_rank});

  assign lvl_eff  = (int'(tree_levels) > MAX_LEVELS) ? LVL_W'(MAX_LEVELS)
                                                     : LVL_W'(tree_levels);
  assign axes_eff = (axis_count == 2'd0) ? 2'd1 : axis_count;

  // slot wrapped to the table depth, a constant table over every slot value
  always_comb begin
    wr_addr = '0;
    for (int v = 0; v < (1 << SLOT_W); v++) begin
      if (s_tdata[SLOT_W-1:0] == SLOT_W'(v)) begin
        wr_addr = IDX_W'(v % TABLE_DEPTH);
      end
    end
  end

  always_comb begin
    case (axis_idx)
      2'd0:    coord_sel = coord_x;
      2'd1:    coord_sel = coord_y;
      default: coord_sel = coord_z;
    endcase
    go_right  = !($signed(coord_sel) < $signed(cut_q));
    node_next = {node[NODE_W-2:0], go_right};

    // node and 2^level kept modulo the table depth, one step per level
    node_dbl      = {node_mod, go_right};
    node_mod_next = (node_dbl >= DEPTH_V) ? IDX_W'(node_dbl - DEPTH_V)
                                          : node_dbl[IDX_W-1:0];
    pow_dbl       = {pow_mod, 1'b0};
    pow_mod_next  = (pow_dbl >= DEPTH_V) ? IDX_W'(pow_dbl - DEPTH_V)
                                         : pow_dbl[IDX_W-1:0];
    leaf_idx      = (node_mod_next >= pow_mod_next)
                    ? IDX_W'(node_mod_next - pow_mod_next)
                    : IDX_W'({1'b0, node_mod_next} + DEPTH_V - {1'b0, pow_mod_next});

    last_lvl  = (LVL_W'(lvl_cnt + 1'b1) == lvl_total);
    // the top set bit of the leaf node marks the depth; clearing it gives the leaf
    leaf_full = node_next ^ (NODE_W'(1) << lvl_total);
    leaf_ext  = {{SLOT_W{1'b0}}, leaf_full};

    case (state)
      IDLE:    rd_addr = (lvl_eff == '0) ? '0 : IDX_W'(1);
      WALK:    rd_addr = last_lvl ? leaf_idx : node_mod_next;
      default: rd_addr = leaf_addr;
    endcase
  end

  // table memories: one write port used only while idle, one registered read
  always_ff @(posedge clk) begin
    if (load_acc) begin
      cut_mem[wr_addr]  <= s_tdata[CUT_LO +: COORD_WIDTH];
      rank_mem[wr_addr] <= s_tdata[RANK_LO +: RANK_W];
    end
    cut_q  <= cut_mem[rd_addr];
    rank_q <= rank_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      m_tvalid    <= 1'b0;
      axis_count  <= AXIS_COUNT_RST;
      tree_levels <= TREE_LEVELS_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_AXIS_COUNT:  axis_count  <= cfg_data[1:0];
          REG_TREE_LEVELS: tree_levels <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && (state != DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (locate_acc) begin
            coord_x   <= s_tdata[X_LO +: COORD_WIDTH];
            coord_y   <= s_tdata[Y_LO +: COORD_WIDTH];
            coord_z   <= s_tdata[Z_LO +: COORD_WIDTH];
            lvl_total <= lvl_eff;
            lvl_cnt   <= '0;
            axis_idx  <= 2'd0;
            axis_last <= axes_eff - 2'd1;
            node      <= NODE_W'(1);
            node_mod  <= IDX_W'(1);
            pow_mod   <= IDX_W'(1);
            leaf_cur  <= '0;
            leaf_addr <= '0;
            state     <= (lvl_eff == '0) ? DONE : WALK;
          end
        end
        WALK: begin
          node     <= node_next;
          node_mod <= node_mod_next;
          pow_mod  <= pow_mod_next;
          lvl_cnt  <= LVL_W'(lvl_cnt + 1'b1);
          axis_idx <= (axis_idx == axis_last) ? 2'd0 : 2'(axis_idx + 2'd1);
          if (last_lvl) begin
            leaf_cur  <= leaf_ext[SLOT_W-1:0];
            leaf_addr <= leaf_idx;
            state     <= DONE;
          end
        end
        DONE: begin
          // rank memory keeps reading the leaf while the output register is busy
          if (!m_tvalid || m_tready) begin
            owner_rank <= rank_q;
            leaf_slot  <= leaf_cur;
            m_tvalid   <= 1'b1;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- tb/sv/tb_kd_cut_tree_rank_lookup_unit.sv -----
// testbench for the cut-tree rank lookup unit: random load and locate words checked against a predictor
`timescale 1ns / 1ps

module tb_kd_cut_tree_rank_lookup_unit
  import kdcut_pkg::*;
;

  localparam int COORD_W = COORD_WIDTH_DEF;
  localparam int S_W     = ((SLOT_W+RANK_W+4*COORD_W+7)/8)*8;
  localparam int M_W     = ((RANK_W+SLOT_W+7)/8)*8;
  localparam int CUT_LSB = SLOT_W;
  localparam int RNK_LSB = CUT_LSB+COORD_W;
  localparam int X_LSB   = RNK_LSB+RANK_W;
  localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic                act;
    logic [SLOT_W-1:0]   slot;
    logic [COORD_W-1:0]  cut;
    logic [RANK_W-1:0]   rank;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [COORD_W-1:0]  cz;
  } lookup_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [SLOT_W-1:0] leaf;
  } owner_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_W-1:0]        s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_W-1:0]        m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // pending words, expected owners, and the predictor's copy of the tables
  lookup_t          lookup_q[$];
  owner_t           owner_q[$];
  lookup_t          cur_word;
  logic [COORD_W-1:0] cut_shadow [TABLE_DEPTH_DEF];
  logic [RANK_W-1:0]  rank_shadow[TABLE_DEPTH_DEF];
  logic [1:0]       axes_reg   = AXIS_COUNT_RST;
  logic [2:0]       levels_reg = TREE_LEVELS_RST;

  // generator's view: which slots are loaded and with what cut
  logic [COORD_W-1:0] gen_cut[TABLE_DEPTH_DEF];
  bit                 gen_loaded[TABLE_DEPTH_DEF];

  int src_idle_pct = 6;
  int snk_idle_pct = 57;
  bit hold_arm     = 1'b0;
  bit hold_done    = 1'b0;
  int hold_cnt     = 0;
  int err_cnt      = 0;

  kd_cut_tree_rank_lookup_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // walk the cut tree for one point
  function automatic owner_t locate_owner(lookup_t w);
    int lv, ax, node, d, leaf;
    logic [COORD_W-1:0] c;
    owner_t r;
    lv = (levels_reg > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : int'(levels_reg);
    ax = (axes_reg == 0) ? 1 : int'(axes_reg);
    node = 1;
    d = 0;
    for (int k = 0; k < lv; k++) begin
      case (d)
        0: c = w.cx;
        1: c = w.cy;
        default: c = w.cz;
      endcase
      if ($signed(c) < $signed(cut_shadow[node % TABLE_DEPTH_DEF])) node = node * 2;
      else node = node * 2 + 1;
      d = (d + 1) % ax;
    end
    leaf = node - (1 << lv);
    r.rank = rank_shadow[leaf % TABLE_DEPTH_DEF];
    r.leaf = leaf[SLOT_W-1:0];
    return r;
  endfunction

  function automatic logic [S_W-1:0] pack_word(lookup_t w);
    logic [S_W-1:0] d;
    d = '0;
    d[SLOT_W-1:0]              = w.slot;
    d[CUT_LSB +: COORD_W]      = w.cut;
    d[RNK_LSB +: RANK_W]       = w.rank;
    d[X_LSB +: COORD_W]        = w.cx;
    d[X_LSB+COORD_W +: COORD_W]   = w.cy;
    d[X_LSB+2*COORD_W +: COORD_W] = w.cz;
    return d;
  endfunction

  function automatic logic [COORD_W-1:0] pick_extreme();
    case ($urandom_range(3))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_cut();
    if ($urandom_range(99) < 10) return pick_extreme();
    return COORD_W'($urandom);
  endfunction

  // often close to a cut from the generator's table so both branches and equality get hit
  function automatic logic [COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 15) return pick_extreme();
    if (r < 60) return gen_cut[$urandom_range(TABLE_DEPTH_DEF-1)]
                       + COORD_W'($urandom_range(4)) - COORD_W'(2);
    return COORD_W'($urandom);
  endfunction

  function automatic void add_load(int s, logic [COORD_W-1:0] c, logic [RANK_W-1:0] r);
    lookup_t w;
    w.act  = ACT_LOAD;
    w.slot = SLOT_W'(s);
    w.cut  = c;
    w.rank = r;
    w.cx   = COORD_W'($urandom);
    w.cy   = COORD_W'($urandom);
    w.cz   = COORD_W'($urandom);
    lookup_q = {lookup_q, w};
    gen_loaded[s] = 1'b1;
    gen_cut[s]    = c;
  endfunction

  function automatic void add_locate(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                     logic [COORD_W-1:0] z);
    lookup_t w;
    w.act  = ACT_LOCATE;
    w.slot = SLOT_W'($urandom);
    w.cut  = COORD_W'($urandom);
    w.rank = RANK_W'($urandom);
    w.cx   = x;
    w.cy   = y;
    w.cz   = z;
    lookup_q = {lookup_q, w};
  endfunction

  // load every slot a walk of this depth can read, so no unwritten entry is touched
  function automatic void fill_tables(logic [2:0] lv);
    int eff;
    eff = (lv > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : int'(lv);
    for (int s = 0; s < (1 << eff); s++)
      if (!gen_loaded[s]) add_load(s, pick_cut(), RANK_W'($urandom));
  endfunction

  function automatic void add_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 30)
        add_load($urandom_range(TABLE_DEPTH_DEF-1), pick_cut(), RANK_W'($urandom));
      else
        add_locate(pick_coord(), pick_coord(), pick_coord());
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_AXIS_COUNT) axes_reg = val[1:0];
    else levels_reg = val[2:0];
  endtask

  // loads give no result, so the wait runs on past the last owner's arrival
  task automatic wait_idle();
    while (lookup_q.size() != 0 || s_tvalid || owner_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_phase(logic [2:0] ac_val, logic [2:0] lv_val, int n, bit hold);
    wait_idle();
    write_reg(REG_AXIS_COUNT, ac_val);
    write_reg(REG_TREE_LEVELS, lv_val);
    fill_tables(lv_val);
    add_random(n);
    if (hold) hold_arm = 1'b1;
  endtask

  // sender: predicts each accepted word, then offers the next
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (cur_word.act == ACT_LOAD) begin
          cut_shadow[cur_word.slot]  = cur_word.cut;
          rank_shadow[cur_word.slot] = cur_word.rank;
        end else begin
          owner_q = {owner_q, locate_owner(cur_word)};
        end
      end
      if (!s_tvalid || s_tready) begin
        if (lookup_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_word = lookup_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= cur_word.act;
          s_tdata  <= pack_word(cur_word);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    owner_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.rank = m_tdata[RANK_W-1:0];
        got.leaf = m_tdata[RANK_W +: SLOT_W];
        if (owner_q.size() == 0) begin
          $error("unexpected result word: owner_rank %0h leaf_slot %0d", got.rank, got.leaf);
          err_cnt++;
        end else begin
          want = owner_q.pop_front();
          if (got.rank !== want.rank) begin
            $error("owner_rank: expected %0h, got %0h", want.rank, got.rank);
            err_cnt++;
          end
          if (got.leaf !== want.leaf) begin
            $error("leaf_slot: expected %0d, got %0d", want.leaf, got.leaf);
            err_cnt++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (hold_arm && !hold_done) begin
        // long back-pressure so the unit fills up and stalls its input
        hold_cnt  = HOLD_CYCLES;
        hold_done = 1'b1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: no levels, the owner always comes from slot 0
    add_load(0, C_MIN, 16'hffff);
    add_locate(C_MAX, C_MAX, C_MAX);
    add_load(0, C_MAX, 16'h0000);
    add_locate(C_MIN, C_MIN, C_MIN);

    // one level on x: equal goes right, less goes left, at both extremes
    wait_idle();
    write_reg(REG_AXIS_COUNT, 3'd1);
    write_reg(REG_TREE_LEVELS, 3'd1);
    add_load(1, '0, 16'h00a5);
    add_locate('0, COORD_W'($urandom), COORD_W'($urandom));
    add_locate('1, COORD_W'($urandom), COORD_W'($urandom));
    add_load(1, C_MIN, 16'h5a00);
    add_locate(C_MIN, C_MAX, C_MAX);
    add_load(1, C_MAX, 16'h1234);
    add_locate(C_MAX, C_MIN, C_MIN);
    add_locate(C_MAX - COORD_W'(1), C_MAX, C_MAX);

    // zero axis count stays on x; levels above the maximum saturate
    wait_idle();
    write_reg(REG_AXIS_COUNT, 3'd0);
    write_reg(REG_TREE_LEVELS, 3'd7);
    fill_tables(3'd7);
    add_locate(C_MIN, C_MAX, C_MAX);
    add_locate(C_MAX, C_MIN, C_MIN);
    add_random(30);

    run_phase(3'd3, 3'd6, 90, 1'b0);
    run_phase(3'd2, 3'd3, 80, 1'b0);
    run_phase(3'd1, 3'd2, 70, 1'b0);

    wait_idle();
    src_idle_pct = 57;
    snk_idle_pct = 6;
    run_phase(3'd3, 3'd5, 90, 1'b1);
    run_phase(3'd0, 3'd6, 80, 1'b0);
    run_phase(3'd2, 3'd1, 70, 1'b0);

    wait_idle();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_phase(3'd3, 3'd7, 90, 1'b0);
    // upper data bit is outside the axis count field
    run_phase(3'd5, 3'd4, 80, 1'b0);
    run_phase(3'd6, 3'd6, 70, 1'b0);
    run_phase(3'd3, 3'd0, 30, 1'b0);

    wait_idle();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/kdcut_pkg.sv
sv/kd_cut_tree_rank_lookup_unit.sv
tb/sv/tb_kd_cut_tree_rank_lookup_unit.sv
